// ===== src/ffa_pkg.sv =====
// ---------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit free-list allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

  localparam int ADDR_W   = 13;  // block_address width
  localparam int BYTES_W  = 16;  // request_bytes width
  localparam int CFG_W    = 13;  // configuration data width
  localparam int NEED_W   = 17;  // quanta needed by an allocate, header included
  localparam int UADDR_W  = 12;  // user_address width
  localparam int GRANT_W  = 13;  // granted_quanta width

  // result status codes
  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_OOM       = 2'd1,
    ST_FREED     = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  // request mode codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // configuration register indexes
  localparam logic CFG_MIN_CHUNK = 1'b0;
  localparam logic CFG_POOL      = 1'b1;

  // classified command kinds
  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_IGNORE = 2'd2
  } cmd_kind_t;

  // one classified command word in the queue
  typedef struct packed {
    cmd_kind_t           kind;
    logic [NEED_W-1:0]   need;
    logic [ADDR_W-1:0]   addr;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/ffa_ram.sv =====
// ---------------------------------------------------------------------------
// ffa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffa_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/ffa_front.sv =====
// ---------------------------------------------------------------------------
// ffa_front
// Accepts requests, works out quanta needed and pool range, queues commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffa_front import ffa_pkg::*; #(
  parameter int POOL_QUANTA   = 4096,
  parameter int QUANTUM_BYTES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode,
  input  wire logic [BYTES_W-1:0] request_bytes,
  input  wire logic [ADDR_W-1:0]  block_address,
  input  wire logic [CFG_W-1:0]   pool_quanta,
  input  wire logic               cmd_pop,
  output logic                    cmd_valid,
  output cmd_t                    cmd
);

  localparam int PW = ($clog2(POOL_QUANTA) + 2 > CFG_W + 1) ?
                      $clog2(POOL_QUANTA) + 2 : CFG_W + 1;
  localparam logic [PW-1:0]     PoolMax = PW'(POOL_QUANTA);
  localparam logic [NEED_W-1:0] Qb      = NEED_W'(QUANTUM_BYTES);

  logic [PW-1:0]     eff_pool;
  logic [NEED_W-1:0] need;
  logic              ignore;
  cmd_t              entry;
  logic              push;

  cmd_t      q [2];
  logic      wr_ptr;
  logic      rd_ptr;
  logic [1:0] count;

  // classify the incoming word
  always_comb begin
    eff_pool = (PW'(pool_quanta) < PoolMax) ? PW'(pool_quanta) : PoolMax;
    need     = (NEED_W'(request_bytes) + Qb - NEED_W'(1)) / Qb + NEED_W'(1);
    ignore   = (block_address == '0) || (PW'(block_address) >= eff_pool);
    entry.need = need;
    entry.addr = block_address;
    if (mode == MODE_ALLOC) begin
      entry.kind = CMD_ALLOC;
    end else if (ignore) begin
      entry.kind = CMD_IGNORE;
    end else begin
      entry.kind = CMD_FREE;
    end
  end

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/ffa_back.sv =====
// ---------------------------------------------------------------------------
// ffa_back
// Executes queued commands: first-fit search, split, carve and ordered insert.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffa_back import ffa_pkg::*; #(
  parameter int POOL_QUANTA = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  input  cmd_t                     cmd,
  output logic                     cmd_pop,
  input  wire logic [CFG_W-1:0]    min_chunk_quanta,
  input  wire logic [CFG_W-1:0]    pool_quanta,
  output logic                     done,
  output logic [1:0]               status,
  output logic [UADDR_W-1:0]       user_address,
  output logic [GRANT_W-1:0]       granted_quanta
);

  localparam int NW = $clog2(POOL_QUANTA) + 1;       // node index, sentinel included
  localparam int AW = NW - 1;                        // header store address
  localparam int HW = 2 * NW;                        // header word: link and size
  localparam int CW = ((NW > NEED_W) ? NW : NEED_W) + 2;
  localparam int WalkLimit = 3 * (POOL_QUANTA + 2);
  localparam int SW = $clog2(WalkLimit + 2);
  localparam logic [NW-1:0] Sent    = NW'(POOL_QUANTA);
  localparam logic [CW-1:0] PoolMax = CW'(POOL_QUANTA);
  localparam logic [SW-1:0] StepMax = SW'(WalkLimit);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_START  = 12'b000000000010,
    S_APREV  = 12'b000000000100,
    S_AFIT   = 12'b000000001000,
    S_AWR2   = 12'b000000010000,
    S_AROV   = 12'b000000100000,
    S_AADV   = 12'b000001000000,
    S_FBLK   = 12'b000010000000,
    S_ISCAN  = 12'b000100000000,
    S_IRIGHT = 12'b001000000000,
    S_IWBLK  = 12'b010000000000,
    S_IWP    = 12'b100000000000
  } state_t;

  state_t state;

  // allocator state
  logic [NW-1:0] sent_link;
  logic [NW-1:0] rover;
  logic          started;
  logic [NW-1:0] pool_top;

  // working registers
  cmd_t          cur;
  logic [NW-1:0] prev;
  logic [NW-1:0] prev_size;
  logic [NW-1:0] cur_p;
  logic [NW-1:0] split_p;
  logic [SW-1:0] a_steps;
  logic [SW-1:0] i_steps;
  logic [NW-1:0] blk;
  logic [NW-1:0] blk_size;
  logic [NW-1:0] blk_link;
  logic [NW-1:0] ins_p;
  logic [NW-1:0] ins_psize;
  logic          by_carve;
  logic [NW-1:0] carve_end;
  logic [NW-1:0] rd_node;

  // header store ports
  logic          rd_en;
  logic [NW-1:0] rd_x;
  logic [HW-1:0] rdata;
  logic          hw_we;
  logic [NW-1:0] hw_x;
  logic [NW-1:0] hw_link;
  logic [NW-1:0] hw_size;
  logic          ram_we;

  // decoded read data and helpers
  logic [NW-1:0] node_link;
  logic [NW-1:0] node_size;
  logic [NW-1:0] rover_eff;
  logic [NW-1:0] free_blk;
  logic [CW-1:0] eff_pool;
  logic [CW-1:0] need_w;
  logic [CW-1:0] carve_n;
  logic          carve_ok;
  logic          fit;
  logic          exact;
  logic [NW-1:0] s_rem;
  logic          a_over;
  logic          i_over;
  logic [CW-1:0] rb;
  logic [CW-1:0] rp;
  logic [CW-1:0] rn;
  logic          brk;
  logic          rmerge;
  logic          lmerge;

  ffa_ram #(
    .WIDTH (HW),
    .DEPTH (POOL_QUANTA)
  ) u_hdr (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hw_x[AW-1:0]),
    .wdata ({hw_link, hw_size}),
    .re    (rd_en),
    .raddr (rd_x[AW-1:0]),
    .rdata (rdata)
  );

  // header view of the node read most recently
  always_comb begin
    if (rd_node == Sent) begin
      node_link = sent_link;
    end else if (rd_node < Sent) begin
      node_link = rdata[HW-1:NW];
    end else begin
      node_link = '0;
    end
    node_size = (rd_node < Sent) ? rdata[NW-1:0] : '0;
  end

  // search, carve and insert decisions
  always_comb begin
    rover_eff = started ? rover : Sent;
    free_blk  = NW'(cur.addr) - NW'(1);
    eff_pool  = (CW'(pool_quanta) < PoolMax) ? CW'(pool_quanta) : PoolMax;
    need_w    = CW'(cur.need);
    carve_n   = (need_w < CW'(min_chunk_quanta)) ? CW'(min_chunk_quanta) : need_w;
    carve_ok  = (CW'(pool_top) + carve_n) <= eff_pool;
    fit       = CW'(node_size) >= need_w;
    exact     = CW'(node_size) == need_w;
    s_rem     = node_size - cur.need[NW-1:0];
    a_over    = (a_steps + SW'(1)) > StepMax;
    i_over    = (i_steps + SW'(1)) > StepMax;
    rb        = (blk == Sent) ? '0 : CW'(blk) + CW'(1);
    rp        = (ins_p == Sent) ? '0 : CW'(ins_p) + CW'(1);
    rn        = (node_link == Sent) ? '0 : CW'(node_link) + CW'(1);
    brk       = ((rb > rp) && (rb < rn)) || ((rp >= rn) && ((rb > rp) || (rb < rn)));
    rmerge    = (node_link != Sent) && ((CW'(blk) + CW'(blk_size)) == CW'(node_link));
    lmerge    = (ins_p != Sent) && ((CW'(ins_p) + CW'(ins_psize)) == CW'(blk));
  end

  // header store read and write requests
  always_comb begin
    rd_en   = 1'b0;
    rd_x    = '0;
    hw_we   = 1'b0;
    hw_x    = '0;
    hw_link = '0;
    hw_size = '0;
    unique case (state)
      S_START: begin
        rd_en = 1'b1;
        rd_x  = (cur.kind == CMD_ALLOC) ? rover_eff : free_blk;
      end
      S_APREV: begin
        rd_en = 1'b1;
        rd_x  = node_link;
      end
      S_AFIT: begin
        if (fit) begin
          hw_we   = 1'b1;
          hw_link = node_link;
          if (exact) begin
            hw_x    = prev;
            hw_size = prev_size;
          end else begin
            hw_x    = cur_p;
            hw_size = s_rem;
          end
        end else if (cur_p == rover) begin
          rd_en = carve_ok;
          rd_x  = rover;
        end else begin
          rd_en = !a_over;
          rd_x  = node_link;
        end
      end
      S_AWR2: begin
        hw_we   = 1'b1;
        hw_x    = split_p;
        hw_size = cur.need[NW-1:0];
      end
      S_AROV, S_FBLK: begin
        rd_en = 1'b1;
        rd_x  = rover;
      end
      S_AADV: begin
        rd_en = !a_over;
        rd_x  = node_link;
      end
      S_ISCAN: begin
        rd_en = brk ? rmerge : !i_over;
        rd_x  = node_link;
      end
      S_IWBLK: begin
        hw_we   = 1'b1;
        hw_x    = blk;
        hw_link = blk_link;
        hw_size = blk_size;
      end
      S_IWP: begin
        hw_we = 1'b1;
        hw_x  = ins_p;
        if (lmerge) begin
          hw_link = blk_link;
          hw_size = ins_psize + blk_size;
        end else begin
          hw_link = blk;
          hw_size = ins_psize;
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_we  = hw_we && (hw_x < Sent);
  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_node <= rd_x;
    end
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      sent_link <= '0;
      rover     <= '0;
      started   <= 1'b0;
      pool_top  <= '0;
      a_steps   <= '0;
      i_steps   <= '0;
    end else begin
      if (hw_we && (hw_x == Sent)) begin
        sent_link <= hw_link;
      end
      unique case (state)
        S_IDLE: begin
          done <= cmd_valid && (cmd.kind == CMD_IGNORE);
          if (cmd_valid) begin
            cur <= cmd;
            if (cmd.kind == CMD_IGNORE) begin
              status         <= ST_IGNORED;
              user_address   <= '0;
              granted_quanta <= '0;
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          done <= 1'b0;
          if (!started) begin
            sent_link <= Sent;
            rover     <= Sent;
            started   <= 1'b1;
          end
          a_steps <= '0;
          prev    <= rover_eff;
          state   <= (cur.kind == CMD_ALLOC) ? S_APREV : S_FBLK;
        end
        S_APREV: begin
          done      <= 1'b0;
          prev_size <= node_size;
          cur_p     <= node_link;
          state     <= S_AFIT;
        end
        S_AFIT: begin
          if (fit) begin
            rover          <= prev;
            status         <= ST_ALLOCATED;
            granted_quanta <= cur.need[GRANT_W-1:0];
            if (exact) begin
              done         <= 1'b1;
              user_address <= UADDR_W'(cur_p + NW'(1));
              state        <= S_IDLE;
            end else begin
              done         <= 1'b0;
              split_p      <= cur_p + s_rem;
              user_address <= UADDR_W'(cur_p + s_rem + NW'(1));
              state        <= S_AWR2;
            end
          end else if (cur_p == rover) begin
            if (carve_ok) begin
              done      <= 1'b0;
              blk       <= pool_top;
              blk_size  <= carve_n[NW-1:0];
              carve_end <= pool_top + carve_n[NW-1:0];
              by_carve  <= 1'b1;
              ins_p     <= rover;
              i_steps   <= '0;
              state     <= S_ISCAN;
            end else begin
              done           <= 1'b1;
              status         <= ST_OOM;
              user_address   <= '0;
              granted_quanta <= '0;
              state          <= S_IDLE;
            end
          end else if (a_over) begin
            done           <= 1'b1;
            status         <= ST_OOM;
            user_address   <= '0;
            granted_quanta <= '0;
            state          <= S_IDLE;
          end else begin
            done      <= 1'b0;
            a_steps   <= a_steps + SW'(1);
            prev      <= cur_p;
            prev_size <= node_size;
            cur_p     <= node_link;
          end
        end
        S_AWR2: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_AROV: begin
          done  <= 1'b0;
          cur_p <= rover;
          state <= S_AADV;
        end
        S_AADV: begin
          if (a_over) begin
            done           <= 1'b1;
            status         <= ST_OOM;
            user_address   <= '0;
            granted_quanta <= '0;
            state          <= S_IDLE;
          end else begin
            done      <= 1'b0;
            a_steps   <= a_steps + SW'(1);
            prev      <= cur_p;
            prev_size <= node_size;
            cur_p     <= node_link;
            state     <= S_AFIT;
          end
        end
        S_FBLK: begin
          done     <= 1'b0;
          blk      <= free_blk;
          blk_size <= node_size;
          by_carve <= 1'b0;
          ins_p    <= rover;
          i_steps  <= '0;
          state    <= S_ISCAN;
        end
        S_ISCAN: begin
          if (brk) begin
            done      <= 1'b0;
            ins_psize <= node_size;
            blk_link  <= node_link;
            state     <= rmerge ? S_IRIGHT : S_IWBLK;
          end else if (i_over) begin
            // walk gave up: a carve keeps its pool top, a free is dropped
            if (by_carve) begin
              done     <= 1'b0;
              pool_top <= carve_end;
              state    <= S_AROV;
            end else begin
              done           <= 1'b1;
              status         <= ST_IGNORED;
              user_address   <= '0;
              granted_quanta <= '0;
              state          <= S_IDLE;
            end
          end else begin
            done    <= 1'b0;
            i_steps <= i_steps + SW'(1);
            ins_p   <= node_link;
          end
        end
        S_IRIGHT: begin
          done     <= 1'b0;
          blk_size <= blk_size + node_size;
          blk_link <= node_link;
          state    <= S_IWBLK;
        end
        S_IWBLK: begin
          done  <= 1'b0;
          state <= S_IWP;
        end
        S_IWP: begin
          rover <= ins_p;
          if (by_carve) begin
            done     <= 1'b0;
            pool_top <= carve_end;
            state    <= S_AROV;
          end else begin
            done           <= 1'b1;
            status         <= ST_FREED;
            user_address   <= '0;
            granted_quanta <= '0;
            state          <= S_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // once started, the free list stays started
  a_started_holds: assert property (@(posedge clk) disable iff (rst)
    started |=> started) else $error("free list lost its started mark");

  // the carve point never passes the store
  a_pool_top_range: assert property (@(posedge clk) disable iff (rst)
    pool_top <= Sent) else $error("pool top beyond header store");

  // single store port use per cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && hw_we)) else $error("header read and write in one cycle");

  // walk counters stop at the limit
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (a_steps <= StepMax) && (i_steps <= StepMax)) else $error("walk counter overran");

  // a command is only taken while no result is pending in the sequencer
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state == S_IDLE) || (state == S_START)) else $error("pop out of idle");
`endif

endmodule

`default_nettype wire

// ===== src/first_fit_free_list_allocator_core.sv =====
// ---------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// First-fit allocator over a quantum pool with a sorted circular free list.
// ---------------------------------------------------------------------------
// sequencing: an ignored free is answered straight from idle; a free reads its
//   block header, walks the list to its insert point and writes two headers; an
//   allocate walks the list from the rover, plus an insert walk per pool-top carve
// throughput: one command in the sequencer at a time, paced by one header
//   read per cycle from the header store; two commands may wait in the queue
// reset: synchronous; clears the free list state and the queue, header store
//   content is undefined until written; results are never stalled
`timescale 1ns / 1ps
`default_nettype none

module first_fit_free_list_allocator_core import ffa_pkg::*; #(
  parameter int POOL_QUANTA   = 4096,
  parameter int QUANTUM_BYTES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode,
  input  wire logic [BYTES_W-1:0] request_bytes,
  input  wire logic [ADDR_W-1:0]  block_address,
  output logic                    done,
  output logic [1:0]              status,
  output logic [UADDR_W-1:0]      user_address,
  output logic [GRANT_W-1:0]      granted_quanta,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  logic [CFG_W-1:0] min_chunk_quanta;
  logic [CFG_W-1:0] pool_quanta;
  logic             cmd_valid;
  logic             cmd_pop;
  cmd_t             cmd;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_chunk_quanta <= CFG_W'(256);
      pool_quanta      <= CFG_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MIN_CHUNK) begin
        min_chunk_quanta <= cfg_data;
      end else begin
        pool_quanta <= cfg_data;
      end
    end
  end

  // request intake and queue
  ffa_front #(
    .POOL_QUANTA   (POOL_QUANTA),
    .QUANTUM_BYTES (QUANTUM_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .request_bytes (request_bytes),
    .block_address (block_address),
    .pool_quanta   (pool_quanta),
    .cmd_pop       (cmd_pop),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd)
  );

  // list sequencer
  ffa_back #(
    .POOL_QUANTA (POOL_QUANTA)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop),
    .min_chunk_quanta (min_chunk_quanta),
    .pool_quanta      (pool_quanta),
    .done             (done),
    .status           (status),
    .user_address     (user_address),
    .granted_quanta   (granted_quanta)
  );

endmodule

`default_nettype wire
